FILE: sv/csom_pkg.sv
// Package for the column slope obstacle marker: types, widths and register codes.
`default_nettype none

package csom_pkg;

    // Shared multiplier: 33 x 33 bits unsigned, so that the high part of a
    // 65-bit squared run still fits one operand.
    localparam int HALF_W = 32;
    localparam int MUL_W  = HALF_W + 1;
    localparam int PROD_W = 2 * MUL_W;

    // Fixed widths of the configuration registers.
    localparam int HEIGHT_W   = 16;
    localparam int LIMIT_W    = 16;
    localparam int LIMIT_SQ_W = 2 * LIMIT_W;
    localparam int MIN_STEP_W = 20;

    // The squared rise is scaled by 2^16 to match the Q8.8 squared limit.
    localparam int SLOPE_FRAC_SHIFT = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] REG_FLAT_HEIGHT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOPE_LIMIT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OBSTACLE_HEIGHT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_STEP_SQ     = 2'd3;

    localparam logic [HEIGHT_W-1:0]   FLAT_HEIGHT_RST     = 16'hFF06;
    localparam logic [LIMIT_W-1:0]    SLOPE_LIMIT_RST     = 16'd256;
    localparam logic [HEIGHT_W-1:0]   OBSTACLE_HEIGHT_RST = 16'd1500;
    localparam logic [MIN_STEP_W-1:0] MIN_STEP_SQ_RST     = 20'd10;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LIM,
        S_DX,
        S_DY,
        S_DZ,
        S_RLO,
        S_RHI,
        S_ACC,
        S_CMP,
        S_EMIT
    } csom_state_t;

    typedef struct packed {
        logic             en;
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } csom_mul_req_t;

endpackage

`default_nettype wire

FILE: sv/csom_mul.sv
// Shared unsigned multiplier with a registered product.
`default_nettype none

module csom_mul (
    input  wire logic                          clk,
    input  wire csom_pkg::csom_mul_req_t       req,
    output logic [csom_pkg::PROD_W-1:0]        prod
);
    import csom_pkg::*;

    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;

    always_comb
    begin
        prod_next = PROD_W'(req.a) * PROD_W'(req.b);
    end

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

FILE: sv/column_slope_obstacle_marker.sv
// Top level of the column slope obstacle marker: sequencer, state and stream ports.
`default_nettype none

// A column start goes straight to the output step, a short step leaves the slope test after
// the squared run, and any other point goes through the full slope test. No new point is
// taken until the sequencer is back in idle; the single 33 x 33 multiplier is used up to six
// times per point under the sequencer.
// The output register lets a new point be taken while the previous result waits.
// Reset (rst_n low, asynchronous) clears the sequencer, the last point and the output valid,
// and loads the register defaults: flat -250, slope 1.0, obstacle 1500, minimum squared step 10.
module column_slope_obstacle_marker #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // Input point stream.
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // From bit 0 up: point_x, point_y, point_z, zero padding to whole bytes.
    input  wire logic [((3*COORD_BITS+7)/8)*8-1:0]    s_tdata,
    // Bit 0: column_start.
    input  wire logic                                 s_tuser,
    // Result stream.
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // From bit 0 up: out_x, out_y, out_z, zero padding to whole bytes.
    output logic [((3*COORD_BITS+7)/8)*8-1:0]         m_tdata,
    // Bit 0: is_obstacle.
    output logic                                      m_tuser,
    // Configuration write channel.
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [csom_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [csom_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import csom_pkg::*;

    localparam int DATA_W = ((3 * COORD_BITS + 7) / 8) * 8;
    // Squared run: sum of two squares of COORD_BITS-bit magnitudes.
    localparam int RUN_W  = 2 * COORD_BITS + 1;
    localparam int DZ2_W  = 2 * COORD_BITS;
    // Right-hand side: 32-bit squared limit times the squared run.
    localparam int RHS_W  = RUN_W + LIMIT_SQ_W;
    localparam int CMP_W  = (RUN_W > MIN_STEP_W) ? RUN_W : MIN_STEP_W;

    // Absolute difference of two signed coordinates; it always fits COORD_BITS bits.
    function automatic logic [COORD_BITS-1:0] abs_diff(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        logic [COORD_BITS:0] d;
        logic [COORD_BITS:0] m;
        d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        m = d[COORD_BITS] ? (~d + 1'b1) : d;
        return m[COORD_BITS-1:0];
    endfunction

    // Sequencer.
    csom_state_t state_reg;
    csom_state_t state_next;

    // Configuration registers.
    logic [HEIGHT_W-1:0]   flat_height_reg;
    logic [HEIGHT_W-1:0]   flat_height_next;
    logic [LIMIT_W-1:0]    slope_limit_reg;
    logic [LIMIT_W-1:0]    slope_limit_next;
    logic [HEIGHT_W-1:0]   obstacle_height_reg;
    logic [HEIGHT_W-1:0]   obstacle_height_next;
    logic [MIN_STEP_W-1:0] min_step_sq_reg;
    logic [MIN_STEP_W-1:0] min_step_sq_next;

    // Last accepted point of the current column.
    logic [COORD_BITS-1:0] last_x_reg;
    logic [COORD_BITS-1:0] last_x_next;
    logic [COORD_BITS-1:0] last_y_reg;
    logic [COORD_BITS-1:0] last_y_next;
    logic [COORD_BITS-1:0] last_z_reg;
    logic [COORD_BITS-1:0] last_z_next;

    // Working registers for the point in flight.
    logic [COORD_BITS-1:0] px_reg;
    logic [COORD_BITS-1:0] px_next;
    logic [COORD_BITS-1:0] py_reg;
    logic [COORD_BITS-1:0] py_next;
    logic [COORD_BITS-1:0] pz_reg;
    logic [COORD_BITS-1:0] pz_next;
    logic [COORD_BITS-1:0] dx_reg;
    logic [COORD_BITS-1:0] dx_next;
    logic [COORD_BITS-1:0] dy_reg;
    logic [COORD_BITS-1:0] dy_next;
    logic [COORD_BITS-1:0] dz_reg;
    logic [COORD_BITS-1:0] dz_next;
    logic [LIMIT_SQ_W-1:0] lim2_reg;
    logic [LIMIT_SQ_W-1:0] lim2_next;
    logic [RUN_W-1:0]      run2_reg;
    logic [RUN_W-1:0]      run2_next;
    logic [DZ2_W-1:0]      dz2_reg;
    logic [DZ2_W-1:0]      dz2_next;
    logic [RHS_W-1:0]      rhs_reg;
    logic [RHS_W-1:0]      rhs_next;
    logic                  obstacle_reg;
    logic                  obstacle_next;

    // Output register.
    logic                  m_tvalid_reg;
    logic                  m_tvalid_next;
    logic [DATA_W-1:0]     m_tdata_reg;
    logic [DATA_W-1:0]     m_tdata_next;
    logic                  m_tuser_reg;
    logic                  m_tuser_next;

    // Handshakes and helpers.
    logic                  in_accept;
    logic                  out_load;
    logic                  short_step;
    logic [COORD_BITS-1:0] in_x;
    logic [COORD_BITS-1:0] in_y;
    logic [COORD_BITS-1:0] in_z;
    logic [PROD_W-1:0]     run2_ext;
    logic [PROD_W-1:0]     prod;
    logic [HEIGHT_W-1:0]   height_sel;
    logic [COORD_BITS+HEIGHT_W-1:0] height_ext;
    logic [COORD_BITS-1:0] z_out;
    csom_mul_req_t         mul_req;

    assign in_x = s_tdata[COORD_BITS-1:0];
    assign in_y = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign in_z = s_tdata[3*COORD_BITS-1:2*COORD_BITS];

    // A new point is taken only when the sequencer is free; the result register
    // beyond it decouples the output side.
    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_load  = (state_reg == S_EMIT) && (!m_tvalid_reg || m_tready);

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    assign run2_ext   = PROD_W'(run2_reg);
    assign short_step = CMP_W'(run2_reg) < CMP_W'(min_step_sq_reg);

    // The selected height is sign-extended and then cut to the coordinate width.
    assign height_sel = obstacle_reg ? obstacle_height_reg : flat_height_reg;
    assign height_ext = {{COORD_BITS{height_sel[HEIGHT_W-1]}}, height_sel};
    assign z_out      = height_ext[COORD_BITS-1:0];

    csom_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    // Next state. A column start needs no arithmetic and goes straight to the
    // output. Otherwise the multiplier squares the limit, dx, dy and dz, then forms the low
    // partial product of limit squared times the squared run and, unless the step is short, the high one.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = s_tuser ? S_EMIT : S_LIM;
                end
            end
            S_LIM:  state_next = S_DX;
            S_DX:   state_next = S_DY;
            S_DY:   state_next = S_DZ;
            S_DZ:   state_next = S_RLO;
            S_RLO:  state_next = short_step ? S_EMIT : S_RHI;
            S_RHI:  state_next = S_ACC;
            S_ACC:  state_next = S_CMP;
            S_CMP:  state_next = S_EMIT;
            S_EMIT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Operands of the shared multiplier in each step. The product is registered and is read
    // in the next step.
    always_comb
    begin
        mul_req = '0;
        unique case (state_reg)
            S_LIM:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = MUL_W'(slope_limit_reg);
                mul_req.b  = MUL_W'(slope_limit_reg);
            end
            S_DX:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = MUL_W'(dx_reg);
                mul_req.b  = MUL_W'(dx_reg);
            end
            S_DY:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = MUL_W'(dy_reg);
                mul_req.b  = MUL_W'(dy_reg);
            end
            S_DZ:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = MUL_W'(dz_reg);
                mul_req.b  = MUL_W'(dz_reg);
            end
            S_RLO:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = MUL_W'(lim2_reg);
                mul_req.b  = MUL_W'(run2_ext[HALF_W-1:0]);
            end
            S_RHI:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = MUL_W'(lim2_reg);
                mul_req.b  = run2_ext[HALF_W+MUL_W-1:HALF_W];
            end
            default:
            begin
                mul_req = '0;
            end
        endcase
    end

    // Datapath and output register next values.
    always_comb
    begin
        last_x_next   = last_x_reg;
        last_y_next   = last_y_reg;
        last_z_next   = last_z_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        pz_next       = pz_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        dz_next       = dz_reg;
        lim2_next     = lim2_reg;
        run2_next     = run2_reg;
        dz2_next      = dz2_reg;
        rhs_next      = rhs_reg;
        obstacle_next = obstacle_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    px_next = in_x;
                    py_next = in_y;
                    pz_next = in_z;
                    dx_next = abs_diff(in_x, last_x_reg);
                    dy_next = abs_diff(in_y, last_y_reg);
                    dz_next = abs_diff(in_z, last_z_reg);
                    if (s_tuser)
                    begin
                        // The first point of a column is flat and becomes the reference.
                        last_x_next   = in_x;
                        last_y_next   = in_y;
                        last_z_next   = in_z;
                        obstacle_next = 1'b0;
                    end
                end
            end
            S_DX:   lim2_next = prod[LIMIT_SQ_W-1:0];
            S_DY:   run2_next = RUN_W'(prod);
            S_DZ:   run2_next = run2_reg + RUN_W'(prod);
            S_RLO:
            begin
                dz2_next = DZ2_W'(prod);
                if (short_step)
                begin
                    // Too close to the last point: flat, and the reference stays.
                    obstacle_next = 1'b0;
                end
            end
            S_RHI:  rhs_next = RHS_W'(prod);
            S_ACC:  rhs_next = rhs_reg + RHS_W'({prod, {HALF_W{1'b0}}});
            S_CMP:
            begin
                obstacle_next = RHS_W'({dz2_reg, {SLOPE_FRAC_SHIFT{1'b0}}}) > rhs_reg;
                last_x_next   = px_reg;
                last_y_next   = py_reg;
                last_z_next   = pz_reg;
            end
            default:
            begin
                obstacle_next = obstacle_reg;
            end
        endcase

        m_tdata_next = m_tdata_reg;
        m_tuser_next = m_tuser_reg;
        if (out_load)
        begin
            m_tdata_next = DATA_W'({z_out, py_reg, px_reg});
            m_tuser_next = obstacle_reg;
        end

        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    // Configuration register writes.
    always_comb
    begin
        flat_height_next     = flat_height_reg;
        slope_limit_next     = slope_limit_reg;
        obstacle_height_next = obstacle_height_reg;
        min_step_sq_next     = min_step_sq_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_FLAT_HEIGHT:     flat_height_next     = cfg_data[HEIGHT_W-1:0];
                REG_SLOPE_LIMIT:     slope_limit_next     = cfg_data[LIMIT_W-1:0];
                REG_OBSTACLE_HEIGHT: obstacle_height_next = cfg_data[HEIGHT_W-1:0];
                REG_MIN_STEP_SQ:     min_step_sq_next     = cfg_data[MIN_STEP_W-1:0];
                default:             min_step_sq_next     = min_step_sq_reg;
            endcase
        end
    end

    // Control state, configuration and the last point.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            flat_height_reg     <= FLAT_HEIGHT_RST;
            slope_limit_reg     <= SLOPE_LIMIT_RST;
            obstacle_height_reg <= OBSTACLE_HEIGHT_RST;
            min_step_sq_reg     <= MIN_STEP_SQ_RST;
            last_x_reg          <= '0;
            last_y_reg          <= '0;
            last_z_reg          <= '0;
            m_tvalid_reg        <= 1'b0;
        end
        else
        begin
            state_reg           <= state_next;
            flat_height_reg     <= flat_height_next;
            slope_limit_reg     <= slope_limit_next;
            obstacle_height_reg <= obstacle_height_next;
            min_step_sq_reg     <= min_step_sq_next;
            last_x_reg          <= last_x_next;
            last_y_reg          <= last_y_next;
            last_z_reg          <= last_z_next;
            m_tvalid_reg        <= m_tvalid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        px_reg       <= px_next;
        py_reg       <= py_next;
        pz_reg       <= pz_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        dz_reg       <= dz_next;
        lim2_reg     <= lim2_next;
        run2_reg     <= run2_next;
        dz2_reg      <= dz2_next;
        rhs_reg      <= rhs_next;
        obstacle_reg <= obstacle_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef NO_ASSERTIONS
    // An accepted point always occupies the sequencer in the following cycle.
    a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg != S_IDLE))
        else $error("sequencer idle after a point transfer");

    // A column start becomes the reference point at once.
    a_start_sets_last : assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser) |=>
            (last_x_reg == $past(s_tdata[COORD_BITS-1:0])))
        else $error("column start did not update the last point");

    // A short step goes straight to the output as flat.
    a_short_flat : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RLO && short_step) |=> (state_reg == S_EMIT && !obstacle_reg))
        else $error("short step not emitted as flat");

    // A result is only raised from the emit step.
    a_valid_from_emit : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == S_EMIT))
        else $error("result valid raised outside the emit step");

    // A free output slot in the emit step always receives the result.
    a_emit_loads : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && (!m_tvalid_reg || m_tready)) |=> m_tvalid_reg)
        else $error("emit step did not load the output register");
`endif

endmodule

`default_nettype wire

FILE: tb/column_slope_obstacle_marker_chk.sv
// Checker for the column slope obstacle marker: tracks registers, predicts each result and compares.
module column_slope_obstacle_marker_chk #(
    parameter int COORD_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    input  logic                                   s_tready,
    input  logic [((3*COORD_BITS+7)/8)*8-1:0]      s_tdata,
    input  logic                                   s_tuser,
    input  logic                                   m_tvalid,
    input  logic                                   m_tready,
    input  logic [((3*COORD_BITS+7)/8)*8-1:0]      m_tdata,
    input  logic                                   m_tuser,
    input  logic                                   cfg_valid,
    input  logic                                   cfg_ready,
    input  logic [csom_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [csom_pkg::CFG_DATA_W-1:0]        cfg_data,
    output int                                     fail_count,
    output int                                     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import csom_pkg::*;

    localparam int CW = COORD_BITS;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 obstacle;
    } marked_point_t;

    marked_point_t expected_marks[$];

    // Last accepted point of the current column and the register copies.
    logic signed [CW-1:0]  last_x;
    logic signed [CW-1:0]  last_y;
    logic signed [CW-1:0]  last_z;
    logic [HEIGHT_W-1:0]   flat_h;
    logic [HEIGHT_W-1:0]   obst_h;
    logic [LIMIT_W-1:0]    slope_lim;
    logic [MIN_STEP_W-1:0] min_step;

    function automatic logic [CW:0] abs_delta(logic signed [CW-1:0] a, logic signed [CW-1:0] b);
        logic signed [CW:0] d;
        d = a - b;
        return (d < 0) ? -d : d;
    endfunction

    function automatic logic [127:0] square(logic [CW:0] v);
        return 128'(v) * 128'(v);
    endfunction

    // Classifies one point against the last accepted one and, unless the step is short, moves that point on.
    function automatic marked_point_t mark_point(logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                                                 logic signed [CW-1:0] pz, logic start);
        marked_point_t m;
        logic [127:0]  run_sq;
        logic [127:0]  rise_term;
        logic [127:0]  limit_term;
        logic          steep;
        steep = 1'b0;
        if (start)
        begin
            last_x = px;
            last_y = py;
            last_z = pz;
        end
        else
        begin
            run_sq = square(abs_delta(px, last_x)) + square(abs_delta(py, last_y));
            // A short step leaves the last point where it is.
            if (run_sq >= 128'(min_step))
            begin
                rise_term  = square(abs_delta(pz, last_z)) << SLOPE_FRAC_SHIFT;
                limit_term = 128'(slope_lim) * 128'(slope_lim) * run_sq;
                last_x = px;
                last_y = py;
                last_z = pz;
                steep = rise_term > limit_term;
            end
        end
        m.x = px;
        m.y = py;
        m.z = $signed(steep ? obst_h : flat_h);
        m.obstacle = steep;
        return m;
    endfunction

    function automatic void check_field(string name, logic signed [CW-1:0] want,
                                        logic signed [CW-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        marked_point_t want;
        marked_point_t got;
        if (!rst_n)
        begin
            expected_marks.delete();
            last_x = '0;
            last_y = '0;
            last_z = '0;
            flat_h = FLAT_HEIGHT_RST;
            slope_lim = SLOPE_LIMIT_RST;
            obst_h = OBSTACLE_HEIGHT_RST;
            min_step = MIN_STEP_SQ_RST;
            fail_count = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_FLAT_HEIGHT:     flat_h = cfg_data[HEIGHT_W-1:0];
                    REG_SLOPE_LIMIT:     slope_lim = cfg_data[LIMIT_W-1:0];
                    REG_OBSTACLE_HEIGHT: obst_h = cfg_data[HEIGHT_W-1:0];
                    REG_MIN_STEP_SQ:     min_step = cfg_data[MIN_STEP_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                got.x = m_tdata[CW-1:0];
                got.y = m_tdata[2*CW-1:CW];
                got.z = m_tdata[3*CW-1:2*CW];
                got.obstacle = m_tuser;
                if (expected_marks.size() == 0)
                begin
                    $error("result transfer with none expected: x %0d, y %0d, z %0d",
                           got.x, got.y, got.z);
                    fail_count++;
                end
                else
                begin
                    want = expected_marks.pop_front();
                    check_field("out_x", want.x, got.x);
                    check_field("out_y", want.y, got.y);
                    check_field("out_z", want.z, got.z);
                    check_field("is_obstacle", CW'(want.obstacle), CW'(got.obstacle));
                end
            end
            if (s_tvalid && s_tready)
                expected_marks.push_back(mark_point(s_tdata[CW-1:0], s_tdata[2*CW-1:CW],
                                                    s_tdata[3*CW-1:2*CW], s_tuser));
            pending <= expected_marks.size();
        end
    end

endmodule

FILE: tb/column_slope_obstacle_marker_tb.sv
// Testbench top for the column slope obstacle marker: stimulus, pacing and verdict.
module column_slope_obstacle_marker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import csom_pkg::*;

    localparam int CW          = 16;
    localparam int DATA_W      = ((3*CW+7)/8)*8;
    localparam int PHASE_ITEMS = 170;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [DATA_W-1:0]     m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int   fail_count;
    int   pending;
    int   cycles = 0;
    // Pacing: chance in a hundred that the point source idles before a point, and that
    // the result sink refuses a cycle. A hold request makes the sink refuse a long stretch.
    int   idle_pct = 0;
    int   stall_pct = 0;
    logic hold_go = 1'b0;
    logic hold_taken = 1'b0;
    int   hold_left = 0;

    column_slope_obstacle_marker #(
        .COORD_BITS (CW)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    column_slope_obstacle_marker_chk #(
        .COORD_BITS (CW)
    ) u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result sink. The long hold-off is counted here so that the point source can keep
    // offering points meanwhile, which fills the block and makes it refuse input.
    always @(posedge clk)
    begin
        if (hold_go && !hold_taken)
        begin
            hold_left = HOLD_CYCLES;
            hold_taken = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Offers one point, after a random number of idle cycles, and returns at the edge
    // of its transfer with tvalid still high, so that back-to-back points need no gap.
    task automatic drive_point(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                               logic signed [CW-1:0] z, logic start);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= DATA_W'({z, y, x});
        s_tuser <= start;
        do @(posedge clk); while (!s_tready);
    endtask

    // Stops offering points and waits until every predicted result has been transferred.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(value);
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Registers change only with the block idle, so the drain comes first.
    task automatic set_regs(int flat, int slope, int obst, int min_sq);
        wait_for_results();
        write_reg(REG_FLAT_HEIGHT, flat);
        write_reg(REG_SLOPE_LIMIT, slope);
        write_reg(REG_OBSTACLE_HEIGHT, obst);
        write_reg(REG_MIN_STEP_SQ, min_sq);
        cfg_valid <= 1'b0;
    endtask

    // Random register values; the unused upper data bits of the two 16-bit height registers are random too.
    task automatic random_regs();
        set_regs($urandom,
                 $urandom_range(1) ? $urandom_range(65535) : $urandom_range(64, 1024),
                 $urandom,
                 ($urandom_range(3) == 0) ? $urandom_range(1000000) : $urandom_range(64));
    endtask

    task automatic set_pacing(int idle, int stall);
        idle_pct = idle;
        stall_pct <= stall;
    endtask

    function automatic int pick_span();
        case ($urandom_range(3))
            0:       return 3;
            1:       return 30;
            2:       return 600;
            default: return 32767;
        endcase
    endfunction

    function automatic int rand_offset(int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    // Mostly well-formed columns: a start point anywhere in range and then a random walk,
    // whose step sizes decide how often points are short steps, flat or obstacles. About
    // one draw in ten is a lone point with a random start flag, which breaks a column.
    task automatic run_columns(int count);
        int                   left;
        int                   len;
        int                   xy_span;
        int                   z_span;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        left = count;
        while (left > 0)
        begin
            x = CW'($urandom);
            y = CW'($urandom);
            z = CW'($urandom);
            if ($urandom_range(9) == 0)
            begin
                drive_point(x, y, z, 1'($urandom_range(1)));
                left--;
            end
            else
            begin
                len = $urandom_range(2, 14);
                xy_span = pick_span();
                z_span = pick_span();
                drive_point(x, y, z, 1'b1);
                left--;
                for (int i = 1; i < len && left > 0; i++)
                begin
                    x = CW'(x + rand_offset(xy_span));
                    y = CW'(y + rand_offset(xy_span));
                    z = CW'(z + rand_offset(z_span));
                    drive_point(x, y, z, 1'b0);
                    left--;
                end
            end
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed points at the reset register values: flat -250, slope 1.0,
        // obstacle 1500, minimum squared step 10.
        // Before any column start the block compares against the zero point:
        // first a short step, then a step of exactly the minimum that is too steep.
        drive_point(0, 0, 0, 1'b0);
        drive_point(3, 1, 5, 1'b0);
        // Column starts at the corners of the range, and the widest possible run.
        drive_point(32767, -32768, 0, 1'b1);
        drive_point(-32768, 32767, -32768, 1'b0);
        drive_point(-32768, -32768, -32768, 1'b1);
        drive_point(-32768, -32768, 32767, 1'b0);
        drive_point(-32767, -32768, 32767, 1'b0);
        drive_point(-32765, -32767, 32767, 1'b0);
        // Rise equal to the limit is flat; one more millimetre makes an obstacle. The
        // short step after it must not move the last point.
        drive_point(0, 0, 0, 1'b1);
        drive_point(4, 0, 4, 1'b0);
        drive_point(8, 0, 9, 1'b0);
        drive_point(9, 1, 9, 1'b0);
        drive_point(12, 0, 13, 1'b0);
        drive_point(100, 100, 0, 1'b1);
        drive_point(101, 101, 50, 1'b0);

        // Zero slope limit and zero minimum step: a zero run with no rise is flat, with any
        // rise it is an obstacle. Heights at the extremes of their range.
        set_regs(-32768, 0, 32767, 0);
        drive_point(5, 5, 5, 1'b1);
        drive_point(5, 5, 5, 1'b0);
        drive_point(5, 5, 6, 1'b0);
        drive_point(6, 5, 6, 1'b0);
        drive_point(7, 5, 100, 1'b0);

        // Largest slope limit and all 20 bits of the minimum step set: a run of 1000 is
        // still short, and the full-range runs give the largest products.
        set_regs(32767, 65535, -32768, 20'hFFFFF);
        drive_point(0, 0, 0, 1'b1);
        drive_point(1000, 0, 0, 1'b0);
        drive_point(-32768, -32768, 32767, 1'b0);
        drive_point(32767, 32767, -32768, 1'b0);

        // Random phases, each with its own registers and its own pacing of both sides.
        for (int phase = 0; phase < 7; phase++)
        begin
            case (phase)
                0:
                begin
                    set_regs(-250, 256, 1500, 10);
                    set_pacing(0, 0);
                end
                1:
                begin
                    random_regs();
                    set_pacing(48, 0);
                end
                2:
                begin
                    random_regs();
                    set_pacing(0, 48);
                end
                3:
                begin
                    random_regs();
                    set_pacing(27, 27);
                end
                4:
                begin
                    // The sink holds off while the source keeps offering points, so the
                    // block backs up; then the source waits for the whole backlog.
                    set_regs(100, 512, -100, 0);
                    set_pacing(0, 0);
                    hold_go <= 1'b1;
                    run_columns(40);
                    wait_for_results();
                end
                5:
                begin
                    set_regs(-32768, 0, 32767, 0);
                    set_pacing(48, 0);
                end
                default:
                begin
                    set_regs(32767, 65535, -32768, 20'hFFFFF);
                    set_pacing(0, 48);
                end
            endcase
            run_columns((phase == 4) ? PHASE_ITEMS - 40 : PHASE_ITEMS);
        end

        wait_for_results();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: column_slope_obstacle_marker.f
sv/csom_pkg.sv
sv/csom_mul.sv
sv/column_slope_obstacle_marker.sv
tb/column_slope_obstacle_marker_chk.sv
tb/column_slope_obstacle_marker_tb.sv
